FILE: rtl/core/pidc_pkg.sv
// shared types, widths and register codes of the two-mode pid controller
package pidc_pkg;

  localparam int GAIN_FRAC_BITS = 16;
  localparam int SAMPLE_WIDTH   = 16;

  localparam int GAIN_W     = 24;
  localparam int ACC_W      = 48;
  localparam int LIMIT_W    = 15;
  localparam int DRIVE_W    = 16;
  localparam int ERR_W      = SAMPLE_WIDTH + 1;
  localparam int PROD_W     = GAIN_W + ERR_W + 2;
  localparam int SUM_W      = ((PROD_W > ACC_W) ? PROD_W : ACC_W) + 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = (GAIN_W > SAMPLE_WIDTH) ? GAIN_W : SAMPLE_WIDTH;

  localparam logic [CFG_IDX_W-1:0] REG_MODE      = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I    = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D    = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_SETPOINT  = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND  = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] REG_OUT_LIMIT = CFG_IDX_W'(6);

  localparam logic MODE_INCR = 1'b0;
  localparam logic MODE_POS  = 1'b1;

  localparam logic [SAMPLE_WIDTH-1:0] SETPOINT_RST  = SAMPLE_WIDTH'(30);
  localparam logic [LIMIT_W-1:0]      DEADBAND_RST  = LIMIT_W'(3);
  localparam logic [LIMIT_W-1:0]      OUT_LIMIT_RST = LIMIT_W'(19000);

  typedef struct packed {
    logic                        mode;
    logic signed [GAIN_W-1:0]       gain_p;
    logic signed [GAIN_W-1:0]       gain_i;
    logic signed [GAIN_W-1:0]       gain_d;
    logic signed [SAMPLE_WIDTH-1:0] setpoint;
    logic        [LIMIT_W-1:0]      deadband;
    logic        [LIMIT_W-1:0]      out_limit;
  } cfg_t;

  typedef struct packed {
    logic signed [ERR_W-1:0] last_error;
    logic signed [ERR_W-1:0] error_before_last;
    logic signed [ACC_W-1:0] integral_sum;
    logic signed [ACC_W-1:0] held_output;
  } state_t;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    logic                      in_deadband;
    logic                      clamped;
  } result_t;

endpackage

FILE: rtl/core/pidc_cfg_regs.sv
// configuration register file of the pid controller
module pidc_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  input  logic [pidc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [pidc_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output pidc_pkg::cfg_t                   cfg_o
);
  import pidc_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_MODE:      cfg_d.mode      = cfg_data_i[0];
        REG_GAIN_P:    cfg_d.gain_p    = cfg_data_i[GAIN_W-1:0];
        REG_GAIN_I:    cfg_d.gain_i    = cfg_data_i[GAIN_W-1:0];
        REG_GAIN_D:    cfg_d.gain_d    = cfg_data_i[GAIN_W-1:0];
        REG_SETPOINT:  cfg_d.setpoint  = cfg_data_i[SAMPLE_WIDTH-1:0];
        REG_DEADBAND:  cfg_d.deadband  = cfg_data_i[LIMIT_W-1:0];
        REG_OUT_LIMIT: cfg_d.out_limit = cfg_data_i[LIMIT_W-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode      <= MODE_POS;
      cfg_q.gain_p    <= '0;
      cfg_q.gain_i    <= '0;
      cfg_q.gain_d    <= '0;
      cfg_q.setpoint  <= SETPOINT_RST;
      cfg_q.deadband  <= DEADBAND_RST;
      cfg_q.out_limit <= OUT_LIMIT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/core/pidc_datapath.sv
// combinational control law: error history, three gain products, integral, clamp
module pidc_datapath (
  input  pidc_pkg::cfg_t                          cfg_i,
  input  logic signed [pidc_pkg::SAMPLE_WIDTH-1:0] meas_i,
  input  pidc_pkg::state_t                        state_i,
  output pidc_pkg::state_t                        state_o,
  output pidc_pkg::result_t                       result_o
);
  import pidc_pkg::*;

  localparam int D1_W  = ERR_W + 1;
  localparam int D2_W  = ERR_W + 2;
  localparam int CMP_W = (ERR_W > LIMIT_W) ? ERR_W : LIMIT_W;
  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic signed [SUM_W-1:0] FRAC_MASK = SUM_W'((64'd1 << GAIN_FRAC_BITS) - 64'd1);

  logic signed [GAIN_W-1:0]       gp, gi, gd;
  logic signed [SAMPLE_WIDTH-1:0] sp;
  logic signed [ERR_W-1:0]        e0, e1, e2;
  logic signed [D1_W-1:0]         d1;
  logic signed [D2_W-1:0]         d2;
  logic signed [PROD_W-1:0]       op_p, op_d, mp, mi, md;
  logic signed [SUM_W-1:0]        y_inc, i_sum, i_sat, y_pos, y_pre, y_clip, y_adj, lim;
  logic        [ERR_W-1:0]        mag;
  logic                           pos, dead, hi, lo;

  assign gp = cfg_i.gain_p;
  assign gi = cfg_i.gain_i;
  assign gd = cfg_i.gain_d;
  assign sp = cfg_i.setpoint;
  assign pos = (cfg_i.mode == MODE_POS);

  assign e0 = ERR_W'(sp) - ERR_W'(meas_i);
  assign e1 = state_i.last_error;
  assign e2 = state_i.error_before_last;
  assign d1 = D1_W'(e0) - D1_W'(e1);
  assign d2 = D2_W'(e0) - (D2_W'(e1) <<< 1) + D2_W'(e2);

  // p and d multipliers are shared between the two modes
  assign op_p = pos ? PROD_W'(e0) : PROD_W'(d1);
  assign op_d = pos ? PROD_W'(d1) : PROD_W'(d2);
  assign mp = PROD_W'(gp) * op_p;
  assign mi = PROD_W'(gi) * PROD_W'(e0);
  assign md = PROD_W'(gd) * op_d;

  assign y_inc = SUM_W'(state_i.held_output) + SUM_W'(mp) + SUM_W'(mi) + SUM_W'(md);

  assign i_sum = SUM_W'(state_i.integral_sum) + SUM_W'(mi);
  always_comb begin
    priority if (i_sum > SUM_W'(ACC_MAX)) begin
      i_sat = SUM_W'(ACC_MAX);
    end else if (i_sum < SUM_W'(ACC_MIN)) begin
      i_sat = SUM_W'(ACC_MIN);
    end else begin
      i_sat = i_sum;
    end
  end
  assign y_pos = i_sat + SUM_W'(mp) + SUM_W'(md);

  assign mag  = e0[ERR_W-1] ? ERR_W'(-e0) : ERR_W'(e0);
  assign dead = pos && (CMP_W'(mag) < CMP_W'(cfg_i.deadband));

  always_comb begin
    if (!pos) begin
      y_pre = y_inc;
    end else if (dead) begin
      y_pre = '0;
    end else begin
      y_pre = y_pos;
    end
  end

  assign lim = SUM_W'(cfg_i.out_limit) << GAIN_FRAC_BITS;
  assign hi  = (y_pre >= lim);
  assign lo  = (y_pre <= -lim);

  always_comb begin
    priority if (hi) begin
      y_clip = lim;
    end else if (lo) begin
      y_clip = -lim;
    end else begin
      y_clip = y_pre;
    end
  end

  // truncate toward zero when dropping the fraction
  assign y_adj = y_clip[SUM_W-1] ? (y_clip + FRAC_MASK) : y_clip;

  always_comb begin
    state_o.last_error        = e0;
    state_o.error_before_last = e1;
    state_o.held_output       = ACC_W'(y_clip);
    if (!pos) begin
      state_o.integral_sum = state_i.integral_sum;
    end else if (dead) begin
      state_o.integral_sum = '0;
    end else begin
      state_o.integral_sum = ACC_W'(i_sat);
    end
  end

  assign result_o.drive       = DRIVE_W'(y_adj >>> GAIN_FRAC_BITS);
  assign result_o.in_deadband = dead;
  assign result_o.clamped     = hi || lo;

endmodule

FILE: rtl/core/pid_controller_two_mode_core.sv
// Two-mode PID controller core: one measured sample in, one drive value out.
//
// Channels: the sample channel (in_valid_i / in_ready_o, measurement_i) and
// the result channel (out_valid_o / out_ready_i, drive_o, in_deadband_o,
// clamped_o) use valid/ready, a transfer at each edge with both high.
// Configuration writes come on cfg_valid_i / cfg_ready_o with cfg_index_i and
// cfg_data_i; cfg_ready_o is always high and a write lands on the next edge.
// Write registers only while no sample is in flight.
//
// The sample is registered at its transfer, the control law (three gain
// products, integral and clamp) works on the registered sample, and the
// result register loads when the result slot is free and drives out_valid_o.
// Throughput is one sample per cycle unless the receiver stalls; the error
// history, integral and held output update with the result register.
//
// Reset loads the register defaults (positional mode, setpoint 30, deadband
// 3, limit 19000, gains 0) and clears errors, integral and held output.
// When the receiver stalls the result holds; one more sample can wait in the
// input register, then in_ready_o drops until the result is taken.
module pid_controller_two_mode_core (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [pidc_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [pidc_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic signed [pidc_pkg::SAMPLE_WIDTH-1:0] measurement_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [pidc_pkg::DRIVE_W-1:0]    drive_o,
  output logic                                   in_deadband_o,
  output logic                                   clamped_o
);
  import pidc_pkg::*;

  cfg_t    cfg_q;
  state_t  state_q, state_d;
  result_t res_q, res_d;

  logic                           in_valid_q;
  logic signed [SAMPLE_WIDTH-1:0] meas_q;
  logic                           out_valid_q;
  logic                           out_free, fire;

  assign cfg_ready_o = 1'b1;

  pidc_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg_q)
  );

  assign out_free   = !out_valid_q || out_ready_i;
  assign fire       = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      meas_q <= measurement_i;
    end
  end

  pidc_datapath u_datapath (
    .cfg_i    (cfg_q),
    .meas_i   (meas_q),
    .state_i  (state_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        state_q <= state_d;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign drive_o       = res_q.drive;
  assign in_deadband_o = res_q.in_deadband;
  assign clamped_o     = res_q.clamped;

  // a deadband result always drives zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && in_deadband_o |-> drive_o == '0)
    else $error("deadband result with nonzero drive");

  // the integral shown alongside a deadband result has been cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && in_deadband_o |-> state_q.integral_sum == '0)
    else $error("integral not cleared in deadband");

  // a clamped result sits on one of the bounds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && clamped_o |->
      (drive_o == DRIVE_W'(cfg_q.out_limit)) ||
      (drive_o == DRIVE_W'(-$signed({1'b0, cfg_q.out_limit}))))
    else $error("clamped drive off the limit");

  // the state only moves when a result is registered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> $stable(state_q))
    else $error("controller state changed without a transfer");

endmodule

FILE: tb/tb_top.sv
// self-checking testbench for the two-mode pid controller core
`timescale 1ns / 1ps

module tb_top;
  import pidc_pkg::*;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int PHASE_ITEMS  = 100;
  localparam int WINDUP_ITEMS = 300;
  localparam int NUM_PHASES   = 11;
  localparam int SMP_MAX      = 2 ** (SAMPLE_WIDTH - 1) - 1;
  localparam int SMP_MIN      = -SMP_MAX - 1;
  localparam int LIMIT_MAX    = 2 ** LIMIT_W - 1;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(7);
  localparam longint ACC_MAX = (longint'(1) <<< (ACC_W - 1)) - 1;
  localparam longint ACC_MIN = -ACC_MAX - 1;
  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1 << GAIN_FRAC_BITS);
  localparam logic [GAIN_W-1:0] GAIN_MAX = {1'b0, {(GAIN_W - 1){1'b1}}};
  localparam logic [GAIN_W-1:0] GAIN_MIN = {1'b1, {(GAIN_W - 1){1'b0}}};

  typedef enum logic [1:0] {ROW_CFG, ROW_SAMPLE, ROW_CHECK} row_e;

  typedef struct packed {
    row_e                           kind;
    logic [CFG_IDX_W-1:0]           idx;
    logic [CFG_DATA_W-1:0]          data;
    logic signed [SAMPLE_WIDTH-1:0] meas;
    result_t                        want;
  } dir_row_t;

  // directed rows: typed results only where they follow directly from the gains
  localparam dir_row_t DIRECTED [32] = '{
    '{ROW_CHECK,  REG_MODE,      '0,            16'sd30,     '{16'sd0,      1'b1, 1'b0}},
    '{ROW_CHECK,  REG_MODE,      '0,            16'sd0,      '{16'sd0,      1'b0, 1'b0}},
    '{ROW_CHECK,  REG_MODE,      '0,            16'sd28,     '{16'sd0,      1'b1, 1'b0}},
    '{ROW_CHECK,  REG_MODE,      '0,            16'sd27,     '{16'sd0,      1'b0, 1'b0}},
    '{ROW_CHECK,  REG_MODE,      '0,            -16'sd32768, '{16'sd0,      1'b0, 1'b0}},
    '{ROW_CHECK,  REG_MODE,      '0,            16'sd32767,  '{16'sd0,      1'b0, 1'b0}},
    '{ROW_CFG,    REG_GAIN_P,    24'h010000,    '0,          '0},
    '{ROW_CHECK,  REG_MODE,      '0,            -16'sd32768, '{16'sd19000,  1'b0, 1'b1}},
    '{ROW_CHECK,  REG_MODE,      '0,            16'sd32767,  '{-16'sd19000, 1'b0, 1'b1}},
    '{ROW_CHECK,  REG_MODE,      '0,            16'sd20,     '{16'sd10,     1'b0, 1'b0}},
    '{ROW_CFG,    REG_OUT_LIMIT, 24'h000000,    '0,          '0},
    '{ROW_CHECK,  REG_MODE,      '0,            16'sd20,     '{16'sd0,      1'b0, 1'b1}},
    '{ROW_CHECK,  REG_MODE,      '0,            16'sd30,     '{16'sd0,      1'b1, 1'b1}},
    '{ROW_CFG,    REG_OUT_LIMIT, 24'h007FFF,    '0,          '0},
    '{ROW_CFG,    REG_GAIN_P,    24'h7FFFFF,    '0,          '0},
    '{ROW_CHECK,  REG_MODE,      '0,            -16'sd32768, '{16'sd32767,  1'b0, 1'b1}},
    '{ROW_CFG,    REG_GAIN_P,    24'h800000,    '0,          '0},
    '{ROW_CHECK,  REG_MODE,      '0,            -16'sd32768, '{-16'sd32767, 1'b0, 1'b1}},
    '{ROW_CFG,    REG_UNUSED,    24'hFFFFFF,    '0,          '0},
    '{ROW_CFG,    REG_MODE,      24'(MODE_INCR), '0,         '0},
    '{ROW_CFG,    REG_GAIN_P,    24'h010000,    '0,          '0},
    '{ROW_CFG,    REG_GAIN_I,    24'h008000,    '0,          '0},
    '{ROW_CFG,    REG_GAIN_D,    24'hFF0000,    '0,          '0},
    '{ROW_SAMPLE, REG_MODE,      '0,            16'sd100,    '0},
    '{ROW_SAMPLE, REG_MODE,      '0,            -16'sd5,     '0},
    '{ROW_SAMPLE, REG_MODE,      '0,            16'sd32767,  '0},
    '{ROW_CFG,    REG_SETPOINT,  24'h008000,    '0,          '0},
    '{ROW_CFG,    REG_DEADBAND,  24'h007FFF,    '0,          '0},
    '{ROW_SAMPLE, REG_MODE,      '0,            16'sd0,      '0},
    '{ROW_CFG,    REG_MODE,      24'(MODE_POS), '0,          '0},
    '{ROW_CHECK,  REG_MODE,      '0,            -16'sd32768, '{16'sd0,      1'b1, 1'b0}},
    '{ROW_SAMPLE, REG_MODE,      '0,            16'sd32767,  '0}
  };

  logic                           clk_i         = 1'b0;
  logic                           rst_ni        = 1'b0;
  logic                           cfg_valid_i   = 1'b0;
  logic [CFG_IDX_W-1:0]           cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0]          cfg_data_i    = '0;
  logic                           in_valid_i    = 1'b0;
  logic signed [SAMPLE_WIDTH-1:0] measurement_i = '0;
  logic                           out_ready_i   = 1'b0;
  logic                           cfg_ready_o;
  logic                           in_ready_o;
  logic                           out_valid_o;
  logic signed [DRIVE_W-1:0]      drive_o;
  logic                           in_deadband_o;
  logic                           clamped_o;

  pid_controller_two_mode_core i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .measurement_i(measurement_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .drive_o      (drive_o),
    .in_deadband_o(in_deadband_o),
    .clamped_o    (clamped_o)
  );

  // controller copy: registers and state as they stand after reset
  logic                           ctl_mode      = MODE_POS;
  logic signed [GAIN_W-1:0]       ctl_gain_p    = '0;
  logic signed [GAIN_W-1:0]       ctl_gain_i    = '0;
  logic signed [GAIN_W-1:0]       ctl_gain_d    = '0;
  logic signed [SAMPLE_WIDTH-1:0] ctl_setpoint  = SETPOINT_RST;
  logic [LIMIT_W-1:0]             ctl_deadband  = DEADBAND_RST;
  logic [LIMIT_W-1:0]             ctl_out_limit = OUT_LIMIT_RST;
  logic signed [ERR_W-1:0]        err_last      = '0;
  logic signed [ERR_W-1:0]        err_prev      = '0;
  logic signed [ACC_W-1:0]        integ_acc     = '0;
  logic signed [ACC_W-1:0]        held_out      = '0;

  result_t drive_q [$];

  bit gaps_on  = 1'b0;
  bit valid_up = 1'b0;
  bit cfg_up   = 1'b0;
  int n_items   = 0;
  int n_checked = 0;
  int n_cfg     = 0;
  int n_err     = 0;
  int n_cycles  = 0;
  int n_clamp   = 0;
  int n_dead    = 0;
  int n_incr    = 0;
  int n_sat     = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  function automatic result_t control_tick(input logic signed [SAMPLE_WIDTH-1:0] meas);
    longint  gp, gi, gd, e0, e1, e2, one, lim, y, acc;
    result_t r;
    gp  = ctl_gain_p;
    gi  = ctl_gain_i;
    gd  = ctl_gain_d;
    e0  = longint'(ctl_setpoint) - longint'(meas);
    e1  = err_last;
    e2  = err_prev;
    one = longint'(1) <<< GAIN_FRAC_BITS;
    lim = longint'(ctl_out_limit) * one;
    r   = '0;
    if (ctl_mode == MODE_INCR) begin
      y = held_out + gp * (e0 - e1) + gi * e0 + gd * (e0 - 2 * e1 + e2);
      n_incr++;
    end else begin
      acc = integ_acc + gi * e0;
      if (acc > ACC_MAX) begin
        acc = ACC_MAX;
        n_sat++;
      end else if (acc < ACC_MIN) begin
        acc = ACC_MIN;
        n_sat++;
      end
      integ_acc = ACC_W'(acc);
      y = gp * e0 + acc + gd * (e0 - e1);
      if ((e0 < 0 ? -e0 : e0) < longint'(ctl_deadband)) begin
        y = 0;
        integ_acc = '0;
        r.in_deadband = 1'b1;
        n_dead++;
      end
    end
    err_prev = err_last;
    err_last = ERR_W'(e0);
    if (y >= lim) begin
      y = lim;
      r.clamped = 1'b1;
    end
    if (y <= -lim) begin
      y = -lim;
      r.clamped = 1'b1;
    end
    if (r.clamped) n_clamp++;
    held_out = ACC_W'(y);
    r.drive = DRIVE_W'(y / one);
    return r;
  endfunction

  function automatic logic signed [SAMPLE_WIDTH-1:0] pick_meas();
    int v;
    int span;
    span = int'(ctl_deadband) + 4;
    case ($urandom_range(0, 9))
      0: v = SMP_MIN;
      1: v = SMP_MAX;
      // close to the setpoint, around the deadband edge
      2, 3: v = int'(ctl_setpoint) + int'($urandom_range(0, 2 * span)) - span;
      default: v = $signed(SAMPLE_WIDTH'($urandom));
    endcase
    if (v > SMP_MAX) v = SMP_MAX;
    if (v < SMP_MIN) v = SMP_MIN;
    return SAMPLE_WIDTH'(v);
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return GAIN_MAX;
      2: return GAIN_MIN;
      3: return GAIN_ONE;
      4: return -GAIN_ONE;
      5, 6: return GAIN_W'($urandom_range(0, 32'h3FFFF) - 32'h20000);
      default: return GAIN_W'($urandom);
    endcase
  endfunction

  // registers change only with nothing in flight
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    if (valid_up) begin
      in_valid_i <= 1'b0;
      valid_up = 1'b0;
    end
    while (drive_q.size() != 0) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    cfg_up = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_MODE:      ctl_mode      = data[0];
      REG_GAIN_P:    ctl_gain_p    = data[GAIN_W-1:0];
      REG_GAIN_I:    ctl_gain_i    = data[GAIN_W-1:0];
      REG_GAIN_D:    ctl_gain_d    = data[GAIN_W-1:0];
      REG_SETPOINT:  ctl_setpoint  = data[SAMPLE_WIDTH-1:0];
      REG_DEADBAND:  ctl_deadband  = data[LIMIT_W-1:0];
      REG_OUT_LIMIT: ctl_out_limit = data[LIMIT_W-1:0];
      default: ;
    endcase
    n_cfg++;
  endtask

  task automatic send_sample(input logic signed [SAMPLE_WIDTH-1:0] meas,
                             input bit typed, input result_t want);
    result_t got;
    if (cfg_up) begin
      cfg_valid_i <= 1'b0;
      cfg_up = 1'b0;
    end
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      if (valid_up) in_valid_i <= 1'b0;
      valid_up = 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    measurement_i <= meas;
    valid_up = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    got = control_tick(meas);
    drive_q.push_back(typed ? want : got);
    n_items++;
  endtask

  task automatic setup_phase();
    logic signed [SAMPLE_WIDTH-1:0] sp;
    logic [LIMIT_W-1:0]             db, lim;
    case ($urandom_range(0, 3))
      0: sp = SAMPLE_WIDTH'(SMP_MIN);
      1: sp = SAMPLE_WIDTH'(SMP_MAX);
      2: sp = SAMPLE_WIDTH'($urandom_range(0, 400) - 200);
      default: sp = SAMPLE_WIDTH'($urandom);
    endcase
    case ($urandom_range(0, 3))
      0: db = '0;
      1: db = LIMIT_W'(LIMIT_MAX);
      2: db = LIMIT_W'($urandom_range(0, 40));
      default: db = LIMIT_W'($urandom);
    endcase
    case ($urandom_range(0, 7))
      0: lim = '0;
      1, 2: lim = LIMIT_W'(LIMIT_MAX);
      3, 4: lim = LIMIT_W'($urandom_range(1, 200));
      default: lim = LIMIT_W'($urandom);
    endcase
    write_reg(REG_MODE, CFG_DATA_W'($urandom_range(0, 1)));
    write_reg(REG_GAIN_P, pick_gain());
    write_reg(REG_GAIN_I, pick_gain());
    write_reg(REG_GAIN_D, pick_gain());
    write_reg(REG_SETPOINT, CFG_DATA_W'(sp));
    write_reg(REG_DEADBAND, CFG_DATA_W'(db));
    write_reg(REG_OUT_LIMIT, CFG_DATA_W'(lim));
    if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
  endtask

  // drive the integral into saturation with a sustained full-scale error
  task automatic run_windup(input bit rising);
    logic signed [SAMPLE_WIDTH-1:0] sp, far;
    int k;
    sp  = rising ? SAMPLE_WIDTH'(SMP_MAX) : SAMPLE_WIDTH'(SMP_MIN);
    far = rising ? SAMPLE_WIDTH'(SMP_MIN) : SAMPLE_WIDTH'(SMP_MAX);
    write_reg(REG_MODE, CFG_DATA_W'(MODE_POS));
    write_reg(REG_GAIN_P, pick_gain());
    write_reg(REG_GAIN_I, CFG_DATA_W'(GAIN_MAX));
    write_reg(REG_GAIN_D, pick_gain());
    write_reg(REG_SETPOINT, CFG_DATA_W'(sp));
    write_reg(REG_DEADBAND, CFG_DATA_W'(1));
    write_reg(REG_OUT_LIMIT, CFG_DATA_W'($urandom_range(0, LIMIT_MAX)));
    // zero error first so the integral starts from a clean zero
    send_sample(sp, 1'b0, '0);
    for (k = 0; k < WINDUP_ITEMS; k++) begin
      send_sample(($urandom_range(0, 15) == 0) ? pick_meas() : far, 1'b0, '0);
    end
  endtask

  // result side: random stall bursts while gaps are enabled
  initial begin
    @(posedge clk_i);
    forever begin
      if (gaps_on && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    result_t want;
    result_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{drive_o, in_deadband_o, clamped_o};
      if (drive_q.size() == 0) begin
        n_err++;
        $display("%0t: unexpected result transfer, drive %0d deadband %0b clamped %0b",
                 $time, got.drive, got.in_deadband, got.clamped);
      end else begin
        want = drive_q.pop_front();
        n_checked++;
        if (got.drive !== want.drive || got.in_deadband !== want.in_deadband ||
            got.clamped !== want.clamped) begin
          n_err++;
          $display("%0t: expected drive %0d deadband %0b clamped %0b, got %0d %0b %0b",
                   $time, $signed(want.drive), want.in_deadband, want.clamped,
                   $signed(got.drive), got.in_deadband, got.clamped);
        end
      end
    end
  end

  initial begin
    int k;
    int p;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    gaps_on = 1'b1;
    for (k = 0; k < $size(DIRECTED); k++) begin
      case (DIRECTED[k].kind)
        ROW_CFG:    write_reg(DIRECTED[k].idx, DIRECTED[k].data);
        ROW_SAMPLE: send_sample(DIRECTED[k].meas, 1'b0, '0);
        default:    send_sample(DIRECTED[k].meas, 1'b1, DIRECTED[k].want);
      endcase
    end

    for (p = 0; p < NUM_PHASES; p++) begin
      gaps_on = (p < NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
      if (p == 4 || p == 5) begin
        run_windup(p == 4);
      end else begin
        setup_phase();
        for (k = 0; k < PHASE_ITEMS; k++) send_sample(pick_meas(), 1'b0, '0);
      end
    end

    if (valid_up) in_valid_i <= 1'b0;
    if (cfg_up) cfg_valid_i <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("ran %0d samples (%0d incremental) over %0d register writes, %0d results checked",
             n_items, n_incr, n_cfg, n_checked);
    $display("saw %0d clamped, %0d deadband, %0d integral saturations, %0d mismatches",
             n_clamp, n_dead, n_sat, n_err);
    if (n_err == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
